// ===== rtl/lsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the lottery spawn arbiter.
// No dependencies.
package lsa_pkg;

    localparam int PLATFORM_SLOTS = 16;
    localparam int SLOT_BITS      = 4;
    localparam int INDEX_SLOTS    = 64;
    localparam int INDEX_BITS     = 6;
    localparam int COUNT_BITS     = 7;
    localparam int DEMAND_BITS    = 8;
    localparam int BOOST_BITS     = 16;
    localparam int WEIGHT_BITS    = 17;
    localparam int TOTAL_BITS     = WEIGHT_BITS + SLOT_BITS;
    localparam int RND_BITS       = 32;
    localparam int RND_CNT_BITS   = 5;
    localparam logic [COUNT_BITS-1:0] VM_LIMIT_RESET = 7'd4;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_SPAWN   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [1:0] STAT_ACCEPTED    = 2'd0;
    localparam logic [1:0] STAT_SPAWNED     = 2'd1;
    localparam logic [1:0] STAT_NO_DEMAND   = 2'd2;
    localparam logic [1:0] STAT_AT_CAPACITY = 2'd3;

    typedef struct packed {
        logic [1:0]             mode;
        logic [SLOT_BITS-1:0]   platform;
        logic [DEMAND_BITS-1:0] demand_count;
        logic [RND_BITS-1:0]    random_word;
        logic [INDEX_BITS-1:0]  vm_slot;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  winner;
        logic [INDEX_BITS-1:0] new_index;
        logic [COUNT_BITS-1:0] running_now;
    } result_t;

    // Lottery weight: zero unless demand exceeds running count.
    function automatic logic [WEIGHT_BITS-1:0] slot_weight(
        input logic [DEMAND_BITS-1:0] dem,
        input logic [COUNT_BITS-1:0]  run,
        input logic [BOOST_BITS-1:0]  boost
    );
        logic [DEMAND_BITS-1:0] run_ext;
        run_ext = {1'b0, run};
        if (dem <= run_ext)
            return '0;
        return WEIGHT_BITS'(dem - run_ext) + WEIGHT_BITS'(boost);
    endfunction

endpackage

// ===== rtl/lsa_mod_unit.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: dividend % divisor, one bit per cycle.
// Depends on lsa_pkg.
module lsa_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lsa_pkg::RND_BITS-1:0]   dividend,
    input  logic [lsa_pkg::TOTAL_BITS-1:0] divisor,
    output logic                          done,
    output logic [lsa_pkg::TOTAL_BITS-1:0] rem
);
    logic                            run_reg;
    logic                            done_reg;
    logic [lsa_pkg::RND_CNT_BITS-1:0] cnt_reg;
    logic [lsa_pkg::RND_BITS-1:0]     num_reg;
    logic [lsa_pkg::TOTAL_BITS-1:0]   rem_reg;
    logic [lsa_pkg::TOTAL_BITS:0]     trial;
    logic [lsa_pkg::TOTAL_BITS-1:0]   rem_next;

    always_comb
    begin
        trial = {rem_reg, num_reg[lsa_pkg::RND_BITS-1]};
        if (trial >= {1'b0, divisor})
            rem_next = lsa_pkg::TOTAL_BITS'(trial - {1'b0, divisor});
        else
            rem_next = trial[lsa_pkg::TOTAL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                num_reg <= dividend;
                rem_reg <= '0;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[lsa_pkg::RND_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (divisor == '0 || rem < divisor))
        else $error("remainder not below divisor");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held more than one cycle");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !done_reg)
        else $error("done while running");

endmodule

// ===== rtl/lottery_spawn_arbiter_aging_core.sv =====
`timescale 1ns / 1ps
// Top level of the lottery spawn arbiter with aging.
// Depends on lsa_pkg and lsa_mod_unit.
//
// One transaction at a time: busy is high while an item is worked on and start
// is ignored then. Each item yields exactly one result, shown for one cycle
// with done high; the receiver cannot stall it. Demand writes, releases and
// spawns refused at start (running total at the VM limit) answer the cycle after
// start. A spawn round walks the 16 slots to sum weights and checks the sum. A
// round with no demand answers there. Otherwise it runs a 32-bit serial remainder,
// walks the slots again to find the winner, then scans the winner's index map one
// bit a cycle for a free index below the VM limit (capped at 64); if none is free
// it answers at capacity.
module lottery_spawn_arbiter_aging_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lsa_pkg::in_item_t                   item,
    input  logic                                cfg_we,
    input  logic [lsa_pkg::COUNT_BITS-1:0]      cfg_data,
    output logic                                done,
    output lsa_pkg::result_t                    result
);
    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_DIVGO, S_DIV, S_WALK, S_FIND
    } state_t;

    state_t state_reg;
    logic [lsa_pkg::DEMAND_BITS-1:0] demand_reg  [lsa_pkg::PLATFORM_SLOTS];
    logic [lsa_pkg::COUNT_BITS-1:0]  run_reg     [lsa_pkg::PLATFORM_SLOTS];
    logic [lsa_pkg::BOOST_BITS-1:0]  boost_reg   [lsa_pkg::PLATFORM_SLOTS];
    logic [lsa_pkg::INDEX_SLOTS-1:0] map_reg     [lsa_pkg::PLATFORM_SLOTS];
    logic [lsa_pkg::COUNT_BITS-1:0]  total_run_reg;
    logic [lsa_pkg::COUNT_BITS-1:0]  vm_limit_reg;
    logic [lsa_pkg::SLOT_BITS-1:0]   cnt_reg;
    logic [lsa_pkg::SLOT_BITS-1:0]   win_reg;
    logic [lsa_pkg::COUNT_BITS-1:0]  idx_reg;
    logic [lsa_pkg::TOTAL_BITS-1:0]  total_reg;
    logic [lsa_pkg::TOTAL_BITS-1:0]  target_reg;
    logic [lsa_pkg::RND_BITS-1:0]    rnd_reg;
    logic                            done_reg;
    lsa_pkg::result_t                result_reg;

    logic [lsa_pkg::COUNT_BITS-1:0]  lim;
    logic [lsa_pkg::WEIGHT_BITS-1:0] w_cnt;
    logic [lsa_pkg::TOTAL_BITS-1:0]  w_ext;
    logic                            div_start;
    logic                            div_done;
    logic [lsa_pkg::TOTAL_BITS-1:0]  div_rem;
    logic                            rel_hit;

    assign lim = (vm_limit_reg > lsa_pkg::COUNT_BITS'(lsa_pkg::INDEX_SLOTS)) ?
                 lsa_pkg::COUNT_BITS'(lsa_pkg::INDEX_SLOTS) : vm_limit_reg;
    assign w_cnt = lsa_pkg::slot_weight(demand_reg[cnt_reg], run_reg[cnt_reg],
                                        boost_reg[cnt_reg]);
    assign w_ext = lsa_pkg::TOTAL_BITS'(w_cnt);
    assign div_start = (state_reg == S_DIVGO) && (total_reg != '0);
    assign rel_hit = map_reg[item.platform][item.vm_slot];

    lsa_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rnd_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_run_reg <= '0;
            vm_limit_reg  <= lsa_pkg::VM_LIMIT_RESET;
            cnt_reg       <= '0;
            win_reg       <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            target_reg    <= '0;
            rnd_reg       <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
            for (int s = 0; s < lsa_pkg::PLATFORM_SLOTS; s++)
            begin
                demand_reg[s] <= '0;
                run_reg[s]    <= '0;
                boost_reg[s]  <= '0;
                map_reg[s]    <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                vm_limit_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        result_reg             <= '0;
                        result_reg.running_now <= total_run_reg;
                        done_reg               <= 1'b1;
                        case (item.mode)
                            lsa_pkg::MODE_WRITE:
                                demand_reg[item.platform] <= item.demand_count;
                            lsa_pkg::MODE_RELEASE:
                            begin
                                if (rel_hit)
                                begin
                                    map_reg[item.platform][item.vm_slot] <= 1'b0;
                                    if (run_reg[item.platform] != '0)
                                        run_reg[item.platform] <=
                                            run_reg[item.platform] - 1'b1;
                                    if (total_run_reg != '0)
                                    begin
                                        total_run_reg <= total_run_reg - 1'b1;
                                        result_reg.running_now <=
                                            total_run_reg - 1'b1;
                                    end
                                end
                            end
                            lsa_pkg::MODE_SPAWN:
                            begin
                                if (total_run_reg >= lim)
                                    result_reg.status <= lsa_pkg::STAT_AT_CAPACITY;
                                else
                                begin
                                    done_reg  <= 1'b0;
                                    cnt_reg   <= '0;
                                    total_reg <= '0;
                                    rnd_reg   <= item.random_word;
                                    state_reg <= S_SUM;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SUM:
                begin
                    total_reg <= total_reg + w_ext;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == lsa_pkg::SLOT_BITS'(lsa_pkg::PLATFORM_SLOTS - 1))
                        state_reg <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    if (total_reg == '0)
                    begin
                        result_reg             <= '0;
                        result_reg.status      <= lsa_pkg::STAT_NO_DEMAND;
                        result_reg.running_now <= total_run_reg;
                        done_reg               <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        target_reg <= div_rem;
                        cnt_reg    <= '0;
                        state_reg  <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (w_cnt != '0)
                    begin
                        if (target_reg < w_ext)
                        begin
                            win_reg   <= cnt_reg;
                            idx_reg   <= '0;
                            state_reg <= S_FIND;
                        end
                        else
                        begin
                            target_reg <= target_reg - w_ext;
                            if (boost_reg[cnt_reg] != '1)
                                boost_reg[cnt_reg] <= boost_reg[cnt_reg] + 1'b1;
                        end
                    end
                    // unreachable while target < total; walked off the end means no demand
                    if (cnt_reg == lsa_pkg::SLOT_BITS'(lsa_pkg::PLATFORM_SLOTS - 1) &&
                        !(w_cnt != '0 && target_reg < w_ext))
                    begin
                        result_reg             <= '0;
                        result_reg.status      <= lsa_pkg::STAT_NO_DEMAND;
                        result_reg.running_now <= total_run_reg;
                        done_reg               <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                S_FIND:
                begin
                    if (idx_reg >= lim)
                    begin
                        result_reg             <= '0;
                        result_reg.status      <= lsa_pkg::STAT_AT_CAPACITY;
                        result_reg.running_now <= total_run_reg;
                        done_reg               <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                    else if (!map_reg[win_reg][idx_reg[lsa_pkg::INDEX_BITS-1:0]])
                    begin
                        map_reg[win_reg][idx_reg[lsa_pkg::INDEX_BITS-1:0]] <= 1'b1;
                        run_reg[win_reg]       <= run_reg[win_reg] + 1'b1;
                        boost_reg[win_reg]     <= '0;
                        total_run_reg          <= total_run_reg + 1'b1;
                        result_reg.status      <= lsa_pkg::STAT_SPAWNED;
                        result_reg.winner      <= win_reg;
                        result_reg.new_index   <= idx_reg[lsa_pkg::INDEX_BITS-1:0];
                        result_reg.running_now <= total_run_reg + 1'b1;
                        done_reg               <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_run_reg <= lsa_pkg::COUNT_BITS'(lsa_pkg::INDEX_SLOTS))
        else $error("running total above index slots");
    a_result_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.running_now == total_run_reg)
        else $error("reported running total disagrees with state");
    a_start_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither running nor answered");
    a_walk_target: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> target_reg < total_reg)
        else $error("lottery target not below total weight");

endmodule
